// ===== hw/rtl/iff_pkg.sv =====
// Package for the integer field formatter: constants, mode codes, and the
// job descriptor passed from the front end to the back end. No dependencies.
package iff_pkg;

  localparam int unsigned WidthMaxDefault   = 40;
  localparam int unsigned DigitDepthDefault = 24;

  localparam logic [2:0] ModeSdec = 3'd0;
  localparam logic [2:0] ModeUdec = 3'd1;
  localparam logic [2:0] ModeOct  = 3'd2;
  localparam logic [2:0] ModeHexL = 3'd3;
  localparam logic [2:0] ModeHexU = 3'd4;

  localparam logic [1:0] RadixDec = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowX  = 8'h78;

  // Classified job: everything the back end needs apart from digits.
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  radix_sel;   // RadixDec, RadixOct or RadixHex
    logic        upper;
    logic        alt_oct;
    logic        alt_hex;
    logic [7:0]  sign_ch;
    logic        has_sign;
    logic        left;
    logic        zero_fill;
    logic [5:0]  width;
    logic [5:0]  prec;
    logic        zero_empty;  // zero value with precision zero
  } job_t;

endpackage

// ===== hw/rtl/iff_front.sv =====
// Front end: accepts items, decodes flags, saturates width and precision.
// Depends on iff_pkg.
module iff_front #(
  parameter int unsigned WidthMax = iff_pkg::WidthMaxDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        mode_i,
  input  logic [63:0]       value_i,
  input  logic [1:0]        length_size_i,
  input  logic              ljust_i,
  input  logic              plus_flag_i,
  input  logic              blank_flag_i,
  input  logic              alt_flag_i,
  input  logic              zero_pad_i,
  input  logic signed [6:0] field_width_i,
  input  logic signed [6:0] digit_precision_i,
  output logic              job_valid_o,
  input  logic              job_stall_i,
  output iff_pkg::job_t     job_o
);
  import iff_pkg::*;

  localparam logic [6:0] WMax = 7'(WidthMax);

  logic       valid_q;
  job_t       job_q, job_d;
  logic [2:0] mode;
  logic       wide, neg, has_prec;
  logic [63:0] v;
  logic [6:0] wmag, pmag;

  assign in_stall_o  = valid_q & job_stall_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    mode = (mode_i > ModeHexU) ? ModeUdec : mode_i;
    wide = length_size_i != 2'd0;
    v    = wide ? value_i : {{32{mode == ModeSdec & value_i[31]}}, value_i[31:0]};
    neg  = (mode == ModeSdec) & v[63];
    wmag = field_width_i[6] ? 7'(-field_width_i) : field_width_i;
    if (wmag > WMax) wmag = WMax;
    has_prec = ~digit_precision_i[6];
    pmag = has_prec ? digit_precision_i : 7'd0;
    if (pmag > WMax) pmag = WMax;
    job_d.mag       = neg ? (~v + 64'd1) : v;
    job_d.radix_sel = (mode == ModeOct) ? RadixOct
                    : ((mode >= ModeHexL) ? RadixHex : RadixDec);
    job_d.upper     = mode == ModeHexU;
    job_d.alt_oct   = alt_flag_i & (mode == ModeOct);
    job_d.alt_hex   = alt_flag_i & (mode >= ModeHexL) & (v != 64'd0);
    job_d.has_sign  = (mode == ModeSdec) & (neg | plus_flag_i | blank_flag_i);
    job_d.sign_ch   = neg ? ChMinus : (plus_flag_i ? ChPlus : ChSpace);
    job_d.left      = ljust_i | field_width_i[6];
    job_d.zero_fill = zero_pad_i & ~job_d.left & ~has_prec;
    job_d.width     = wmag[5:0];
    job_d.prec      = pmag[5:0];
    job_d.zero_empty = (v == 64'd0) & has_prec & (pmag == 7'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) job_q <= job_d;
  end

endmodule

// ===== hw/rtl/iff_back.sv =====
// Back end: digit generation (shift-add-3 binary to BCD for decimal, plain
// digit shifts for octal and hex), then the character emitter. Depends on iff_pkg.
module iff_back #(
  parameter int unsigned DigitDepth = iff_pkg::DigitDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_stall_o,
  input  iff_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    char_out_o,
  output logic          last_o
);
  import iff_pkg::*;

  localparam int unsigned CntW      = $clog2(DigitDepth + 1);
  localparam int unsigned IdxW      = $clog2(DigitDepth);
  localparam int unsigned BcdDigits = 20;  // enough for any 64-bit value
  localparam int unsigned BcdW      = 4 * BcdDigits;

  typedef enum logic [2:0] {StIdle, StBcd, StDigits, StPrep, StEmit} state_e;
  typedef enum logic [2:0] {SegLpad, SegPre, SegZpad, SegZext, SegDig, SegRpad} seg_e;

  state_e      state_q;
  seg_e        seg_q;
  job_t        job_q;
  logic [63:0] quo_q;
  logic [BcdW-1:0] work_q;
  logic [5:0]  bit_q;
  logic [7:0]  digs_q [DigitDepth];
  logic [CntW-1:0] cnt_q;
  logic [5:0]  seg_left_q;
  logic [1:0]  pre_i_q;
  logic [5:0]  zext_q, pad_q;
  logic [1:0]  plen_q;
  logic [7:0]  pre_ch [2];
  logic        out_valid_q, out_last_q;
  logic [7:0]  out_ch_q;

  logic [BcdW-1:0] adj;
  logic [3:0]  dig;
  logic [7:0]  dig_ch;
  logic [6:0]  body;
  logic        lead_zero;
  logic [5:0]  zext_c, pad_c;
  logic [1:0]  plen_c;
  logic        emit_slot;
  logic        emit_fire;
  logic [7:0]  ch_c;
  logic        last_c;
  seg_e        nseg;
  logic [5:0]  nseg_len;

  assign dig = (job_q.radix_sel == RadixOct) ? {1'b0, work_q[2:0]} : work_q[3:0];
  assign dig_ch = (dig < 4'd10) ? (ChZero + 8'(dig))
                : ((job_q.upper ? ChUpA : ChLowA) + 8'(dig) - 8'd10);

  assign job_stall_o = state_q != StIdle;
  assign emit_slot   = !out_valid_q || !out_stall_i;
  assign emit_fire   = (state_q == StEmit) && (seg_left_q != 6'd0) && emit_slot;
  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_ch_q;
  assign last_o      = out_last_q;

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int k = 0; k < BcdDigits; k++) begin
      adj[4*k +: 4] = (work_q[4*k +: 4] >= 4'd5) ? work_q[4*k +: 4] + 4'd3
                                                 : work_q[4*k +: 4];
    end
  end

  always_comb begin
    zext_c = ({1'b0, job_q.prec} > 7'(cnt_q)) ? job_q.prec - 6'(cnt_q) : 6'd0;
    lead_zero = (zext_c != 6'd0) ||
                ((cnt_q != '0) && (digs_q[IdxW'(cnt_q - 1'b1)] == ChZero));
    plen_c = 2'(job_q.has_sign) + ((job_q.alt_oct && !lead_zero) ? 2'd1 : 2'd0)
           + (job_q.alt_hex ? 2'd2 : 2'd0);
    body = 7'(plen_c) + 7'(zext_c) + 7'(cnt_q);
    pad_c = ({1'b0, job_q.width} > body) ? 6'(7'(job_q.width) - body) : 6'd0;
  end

  // Next nonempty segment after the current one; none after the right pad.
  function automatic void next_seg(input seg_e s, input job_t j, input logic [5:0] pad,
                                   input logic [1:0] pl, input logic [5:0] zx,
                                   input logic [CntW-1:0] nd, output seg_e ns,
                                   output logic [5:0] nl);
    seg_e t;
    logic [5:0] l;
    t = s;
    l = 6'd0;
    ns = SegRpad;
    nl = 6'd0;
    for (int k = 0; k < 6; k++) begin
      unique case (t)
        SegLpad: t = SegPre;
        SegPre:  t = SegZpad;
        SegZpad: t = SegZext;
        SegZext: t = SegDig;
        SegDig:  t = SegRpad;
        default: t = SegRpad;
      endcase
      unique case (t)
        SegPre:  l = 6'(pl);
        SegZpad: l = j.zero_fill ? pad : 6'd0;
        SegZext: l = zx;
        SegDig:  l = 6'(nd);
        SegRpad: l = (j.left && s != SegRpad) ? pad : 6'd0;
        default: l = 6'd0;
      endcase
      if (l != 6'd0 && nl == 6'd0) begin
        ns = t;
        nl = l;
      end
    end
  endfunction

  always_comb begin
    unique case (seg_q)
      SegLpad, SegRpad: ch_c = ChSpace;
      SegPre:  ch_c = pre_ch[pre_i_q[0]];
      SegZpad, SegZext: ch_c = ChZero;
      default: ch_c = digs_q[IdxW'(seg_left_q - 6'd1)];
    endcase
    next_seg(seg_q, job_q, pad_q, plen_q, zext_q, cnt_q, nseg, nseg_len);
    last_c = (seg_left_q == 6'd1) && (nseg_len == 6'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= emit_fire || (out_valid_q && out_stall_i);
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            quo_q   <= job_i.mag;
            work_q  <= (job_i.radix_sel == RadixDec) ? '0 : {16'd0, job_i.mag};
            bit_q   <= 6'd0;
            cnt_q   <= '0;
            state_q <= (job_i.radix_sel == RadixDec) ? StBcd : StDigits;
          end
        end
        StBcd: begin
          // Shift the magnitude in MSB first; 64 steps leave it in BCD.
          work_q  <= {adj[BcdW-2:0], quo_q[63]};
          quo_q   <= {quo_q[62:0], 1'b0};
          bit_q   <= bit_q + 6'd1;
          if (bit_q == 6'd63) state_q <= StDigits;
        end
        StDigits: begin
          // Store one digit per cycle, least significant first.
          if (job_q.mag == 64'd0) begin
            if (!job_q.zero_empty) begin
              digs_q[0] <= ChZero;
              cnt_q <= CntW'(1);
            end
            state_q <= StPrep;
          end else if (work_q == '0 || cnt_q == CntW'(DigitDepth)) begin
            state_q <= StPrep;
          end else begin
            digs_q[IdxW'(cnt_q)] <= dig_ch;
            cnt_q  <= cnt_q + 1'b1;
            work_q <= (job_q.radix_sel == RadixOct) ? {3'd0, work_q[BcdW-1:3]}
                                                    : {4'd0, work_q[BcdW-1:4]};
          end
        end
        StPrep: begin
          zext_q  <= zext_c;
          pad_q   <= pad_c;
          plen_q  <= plen_c;
          pre_ch[0] <= job_q.has_sign ? job_q.sign_ch : ChZero;
          pre_ch[1] <= job_q.alt_hex ? (job_q.upper ? ChUpX : ChLowX) : ChZero;
          pre_i_q <= 2'd0;
          seg_q   <= SegLpad;
          seg_left_q <= (!job_q.left && !job_q.zero_fill) ? pad_c : 6'd0;
          state_q <= StEmit;
        end
        StEmit: begin
          if (seg_left_q == 6'd0) begin
            if (nseg_len == 6'd0) begin
              state_q <= StIdle;
            end else begin
              seg_q <= nseg;
              seg_left_q <= nseg_len;
            end
          end else if (emit_slot) begin
            out_ch_q    <= ch_c;
            out_last_q  <= last_c;
            if (seg_q == SegPre) pre_i_q <= pre_i_q + 2'd1;
            if (seg_left_q == 6'd1) begin
              if (nseg_len == 6'd0) begin
                state_q <= StIdle;
              end else begin
                seg_q <= nseg;
                seg_left_q <= nseg_len;
              end
            end else begin
              seg_left_q <= seg_left_q - 6'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/integer_field_formatter_top.sv =====
// Top level of the integer field formatter: front end, one-entry job queue
// and back end. Depends on iff_pkg, iff_front and iff_back.
//
// Usage: present one parsed integer conversion on the input ports with
// in_valid_i; it is taken on an edge where in_stall_o is low. The block
// returns the formatted field one character per item on char_out_o, with
// last_o set on the final character; a conversion whose text is empty
// returns nothing. The receiver holds off items with out_stall_i; a
// stalled item stays put and the emitter waits.
// Flow: the item is registered in the front end, then the back end takes
// the job and generates digits. Decimal first converts binary to BCD by
// shift-add-3; all radixes then store one digit per cycle. A setup state
// follows, then one character per cycle (up to 42 characters) while the
// receiver does not stall.
// The back end handles one job at a time and takes no new job until it
// has emitted the last character of the current one. The front end takes the next
// item while the back end is busy and holds it in its register.
// Reset clears all handshake state; no item is pending after reset.
module integer_field_formatter_top #(
  parameter int unsigned WidthMax   = iff_pkg::WidthMaxDefault,
  parameter int unsigned DigitDepth = iff_pkg::DigitDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        mode_i,
  input  logic [63:0]       value_i,
  input  logic [1:0]        length_size_i,
  input  logic              ljust_i,
  input  logic              plus_flag_i,
  input  logic              blank_flag_i,
  input  logic              alt_flag_i,
  input  logic              zero_pad_i,
  input  logic signed [6:0] field_width_i,
  input  logic signed [6:0] digit_precision_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        char_out_o,
  output logic              last_o
);
  import iff_pkg::*;

  job_t job;
  logic job_valid, job_stall;

  iff_front #(.WidthMax(WidthMax)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .value_i, .length_size_i,
    .ljust_i, .plus_flag_i, .blank_flag_i, .alt_flag_i, .zero_pad_i,
    .field_width_i, .digit_precision_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  iff_back #(.DigitDepth(DigitDepth)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .out_valid_o, .out_stall_i, .char_out_o, .last_o
  );

endmodule

// ===== sim/integer_field_formatter_top_tb.sv =====
// Self-checking testbench for integer_field_formatter_top: drives parsed integer
// conversions and checks every emitted character against a built-in predictor.
// Depends on iff_pkg and the integer_field_formatter_top RTL.
module integer_field_formatter_top_tb;
  import iff_pkg::*;

  typedef struct {
    logic [2:0]        mode;
    logic [63:0]       value;
    logic [1:0]        length_size;
    logic              ljust;
    logic              plus_flag;
    logic              blank_flag;
    logic              alt_flag;
    logic              zero_pad;
    logic signed [6:0] field_width;
    logic signed [6:0] digit_precision;
  } conv_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  localparam int unsigned FieldMax  = WidthMaxDefault;
  localparam int unsigned DigitsMax = DigitDepthDefault;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        mode_i;
  logic [63:0]       value_i;
  logic [1:0]        length_size_i;
  logic              ljust_i;
  logic              plus_flag_i;
  logic              blank_flag_i;
  logic              alt_flag_i;
  logic              zero_pad_i;
  logic signed [6:0] field_width_i;
  logic signed [6:0] digit_precision_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        char_out_o;
  logic              last_o;

  integer_field_formatter_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .value_i,
    .length_size_i,
    .ljust_i,
    .plus_flag_i,
    .blank_flag_i,
    .alt_flag_i,
    .zero_pad_i,
    .field_width_i,
    .digit_precision_i,
    .out_valid_o,
    .out_stall_i,
    .char_out_o,
    .last_o
  );

  conv_t     pending_convs[$];  // items waiting to be offered
  fmt_char_t expected_chars[$]; // characters still owed by the block
  conv_t     offered_conv;      // item currently on the input ports
  int        accepted_convs = 0;
  int        mismatches = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  // Idle about 28 percent of the time, except for a quiet stretch mid-run.
  function automatic bit take_gap();
    if (accepted_convs >= 120 && accepted_convs < 170) return 1'b0;
    return $urandom_range(99) < 28;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // Predict the characters of one conversion and append them to the queue.
  function automatic void predict_field(conv_t c);
    logic [2:0]  mode;
    logic [63:0] v;
    logic [63:0] mag;
    logic [7:0]  prefix[2];
    logic [7:0]  digits[DigitsMax];
    logic [7:0]  line[$];
    logic [7:0]  alpha;
    int          fw;
    int          pr;
    int unsigned width;
    int unsigned prec;
    int unsigned radix;
    int unsigned plen;
    int unsigned ndig;
    int unsigned zext;
    int unsigned pad;
    int unsigned d;
    bit          wide;
    bit          left;
    bit          has_prec;
    bit          zero_fill;
    fmt_char_t   fc;

    mode = (c.mode > ModeHexU) ? ModeUdec : c.mode;
    wide = c.length_size != 2'd0;
    left = c.ljust;
    fw = int'(c.field_width);
    pr = int'(c.digit_precision);
    if (fw < 0) begin
      left = 1'b1;
      width = -fw;
    end else begin
      width = fw;
    end
    if (width > FieldMax) width = FieldMax;
    has_prec = pr >= 0;
    prec = has_prec ? pr : 0;
    if (prec > FieldMax) prec = FieldMax;

    v = wide ? c.value : {32'd0, c.value[31:0]};
    mag = v;
    plen = 0;
    if (mode == ModeSdec) begin
      if (!wide) v = {{32{v[31]}}, v[31:0]};
      mag = v[63] ? (~v + 64'd1) : v;
      if (v[63]) prefix[plen++] = ChMinus;
      else if (c.plus_flag) prefix[plen++] = ChPlus;
      else if (c.blank_flag) prefix[plen++] = ChSpace;
    end

    radix = (mode == ModeOct) ? 8 : ((mode >= ModeHexL) ? 16 : 10);
    alpha = (mode == ModeHexU) ? ChUpA : ChLowA;
    ndig = 0;
    if (mag == 64'd0) begin
      if (!(has_prec && prec == 0)) digits[ndig++] = ChZero;
    end else begin
      while (mag != 64'd0 && ndig < DigitsMax) begin
        d = 32'(mag % radix);
        digits[ndig++] = (d < 10) ? 8'(ChZero + d) : 8'(alpha + d - 10);
        mag = mag / radix;
      end
      mag = 64'd1;  // only its nonzero-ness is needed from here on
    end
    zext = (prec > ndig) ? prec - ndig : 0;

    if (c.alt_flag && mode == ModeOct) begin
      if (!(zext > 0 || (ndig > 0 && digits[ndig-1] == ChZero))) prefix[plen++] = ChZero;
    end else if (c.alt_flag && mode >= ModeHexL && mag != 64'd0) begin
      prefix[plen++] = ChZero;
      prefix[plen++] = (mode == ModeHexU) ? ChUpX : ChLowX;
    end

    pad = (width > plen + zext + ndig) ? width - (plen + zext + ndig) : 0;
    zero_fill = !left && c.zero_pad && !has_prec;
    if (!left && !zero_fill) repeat (pad) line.push_back(ChSpace);
    for (int i = 0; i < plen; i++) line.push_back(prefix[i]);
    if (zero_fill) repeat (pad) line.push_back(ChZero);
    repeat (zext) line.push_back(ChZero);
    for (int i = ndig; i > 0; i--) line.push_back(digits[i-1]);
    if (left) repeat (pad) line.push_back(ChSpace);

    foreach (line[i]) begin
      fc.ch = line[i];
      fc.last = (i == line.size() - 1);
      expected_chars.push_back(fc);
    end
  endfunction

  function automatic conv_t make_conv(logic [2:0] mode, logic [63:0] value, logic [1:0] len,
                                      logic [4:0] flags, int fw, int pr);
    conv_t c;
    c.mode = mode;
    c.value = value;
    c.length_size = len;
    {c.ljust, c.plus_flag, c.blank_flag, c.alt_flag, c.zero_pad} = flags;
    c.field_width = fw[6:0];
    c.digit_precision = pr[6:0];
    return c;
  endfunction

  function automatic conv_t random_conv();
    conv_t c;
    c.mode = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    case ($urandom_range(6))
      0: c.value = {$urandom, $urandom};
      1: c.value = 64'($urandom_range(0, 1000));
      2: c.value = 64'd0;
      3: c.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: c.value = ~({$urandom, $urandom} >> $urandom_range(0, 63));
      5: c.value = 64'h8000_0000_0000_0000 >> ($urandom_range(0, 1) * 32);
      default: c.value = {$urandom, $urandom} & 64'hffff;
    endcase
    c.length_size = 2'($urandom_range(0, 3));
    {c.ljust, c.plus_flag, c.blank_flag, c.alt_flag, c.zero_pad} = 5'($urandom);
    c.field_width = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 80) - 40);
    case ($urandom_range(9))
      0, 1, 2, 3: c.digit_precision = -7'sd1;
      4: c.digit_precision = 7'($urandom);
      default: c.digit_precision = 7'($urandom_range(0, 40));
    endcase
    return c;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: offer the next pending item when the port is free; hold while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i        <= 1'b0;
      mode_i            <= ModeSdec;
      value_i           <= '0;
      length_size_i     <= '0;
      ljust_i           <= 1'b0;
      plus_flag_i       <= 1'b0;
      blank_flag_i      <= 1'b0;
      alt_flag_i        <= 1'b0;
      zero_pad_i        <= 1'b0;
      field_width_i     <= '0;
      digit_precision_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        predict_field(offered_conv);
        accepted_convs++;
      end
      if (pending_convs.size() > 0 && !take_gap()) begin
        offered_conv = pending_convs.pop_front();
        in_valid_i        <= 1'b1;
        mode_i            <= offered_conv.mode;
        value_i           <= offered_conv.value;
        length_size_i     <= offered_conv.length_size;
        ljust_i           <= offered_conv.ljust;
        plus_flag_i       <= offered_conv.plus_flag;
        blank_flag_i      <= offered_conv.blank_flag;
        alt_flag_i        <= offered_conv.alt_flag;
        zero_pad_i        <= offered_conv.zero_pad;
        field_width_i     <= offered_conv.field_width;
        digit_precision_i <= offered_conv.digit_precision;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, so the block fills up and stalls its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_convs >= 60) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
    end
  end

  // Monitor: check each accepted character against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    fmt_char_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char_out", int'(char_out_o), 0);
        end else begin
          want = expected_chars.pop_front();
          if (char_out_o !== want.ch) begin
            report_mismatch("char_out", int'(char_out_o), int'(want.ch));
          end
          if (last_o !== want.last) report_mismatch("last", int'(last_o), int'(want.last));
        end
      end
      out_stall_i <= (hold_left > 1) || take_gap();
    end
  end

  initial begin
    rst_ni = 1'b0;

    // Directed corners: flags are {left, plus, space, alt, zero}.
    pending_convs.push_back(make_conv(ModeSdec, 64'h8000_0000, 2'd0, 5'b00000, 0, -1));
    pending_convs.push_back(make_conv(ModeSdec, 64'h8000_0000_0000_0000, 2'd1, 5'b00000, 0, -1));
    pending_convs.push_back(make_conv(ModeUdec, '1, 2'd2, 5'b01100, 63, -1));
    pending_convs.push_back(make_conv(ModeSdec, 64'd0, 2'd0, 5'b00000, 0, 0));
    pending_convs.push_back(make_conv(ModeSdec, 64'd0, 2'd0, 5'b01000, 5, 0));
    pending_convs.push_back(make_conv(ModeOct, 64'd0, 2'd0, 5'b00010, 0, 0));
    pending_convs.push_back(make_conv(ModeOct, '1, 2'd3, 5'b00010, 0, -1));
    pending_convs.push_back(make_conv(ModeOct, 64'd8, 2'd0, 5'b00010, 0, 6));
    pending_convs.push_back(make_conv(ModeHexL, 64'd0, 2'd0, 5'b00010, 4, -1));
    pending_convs.push_back(make_conv(ModeHexL, 64'hdead_beef, 2'd0, 5'b00011, 16, -1));
    pending_convs.push_back(make_conv(ModeHexU, '1, 2'd1, 5'b00010, -64, -1));
    pending_convs.push_back(make_conv(ModeHexU, 64'hab, 2'd0, 5'b10011, 10, 63));
    pending_convs.push_back(make_conv(ModeSdec, 64'd42, 2'd0, 5'b00101, 8, -1));
    pending_convs.push_back(make_conv(ModeSdec, 64'hffff_fff6, 2'd0, 5'b00001, 10, -5));
    pending_convs.push_back(make_conv(ModeSdec, 64'd7, 2'd0, 5'b01000, -12, 3));
    pending_convs.push_back(make_conv(3'd7, 64'h1_0000_0005, 2'd0, 5'b01111, 3, -1));
    pending_convs.push_back(make_conv(3'd5, 64'd123, 2'd3, 5'b00000, 40, 40));
    pending_convs.push_back(make_conv(ModeUdec, 64'd9, 2'd0, 5'b00100, 1, 1));
    pending_convs.push_back(make_conv(ModeOct, 64'o777, 2'd2, 5'b00000, 0, 0));
    pending_convs.push_back(make_conv(ModeHexL, 64'd0, 2'd0, 5'b00010, 0, 0));
    repeat (250) pending_convs.push_back(random_conv());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_convs.size() == 0 && !in_valid_i && expected_chars.size() == 0);
    // Allow a trailing conversion with empty text to finish its digits.
    repeat (1500) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("integer_field_formatter_top: match");
    end else begin
      $display("integer_field_formatter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #(8 * 3_000_000);
    $display("integer_field_formatter_top: mismatch");
    $finish;
  end

endmodule

// ===== integer_field_formatter_top.f =====
hw/rtl/iff_pkg.sv
hw/rtl/iff_front.sv
hw/rtl/iff_back.sv
hw/rtl/integer_field_formatter_top.sv
sim/integer_field_formatter_top_tb.sv
